// ----- sv/llcc_pkg.sv -----
// Package for the laser line column centroid block.
// Holds the back-end state type and the per-column control record; no dependencies.
package llcc_pkg;

    // Control record that travels with each finished column.
    typedef struct packed {
        logic       found;
        logic       bank;
        logic [7:0] thr;
    } t_col_ctl;

    localparam int unsigned ColCtlW = 10;

    localparam int unsigned ScaleNum = 65536;
    localparam int unsigned ScaleW   = 17;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LOAD,
        B_SCALE,
        B_MUL,
        B_HSTART,
        B_HGT,
        B_IDX,
        B_RD,
        B_MEM,
        B_OUT
    } t_back_state;

endpackage

// ----- sv/llcc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module llcc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/llcc_queue.sv -----
// Two-entry queue between the pixel front end and the centroid back end.
// Depends on nothing but its width parameter.
module llcc_queue #(
    parameter int unsigned WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_ent [2];
    logic             r_rd;
    logic             r_wr;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_ent[r_rd];
endmodule

// ----- sv/llcc_div.sv -----
// Restoring divider, one quotient bit per cycle.
// No dependencies; used by the centroid back end.
module llcc_div #(
    parameter int unsigned N  = 45,
    parameter int unsigned DW = 19
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [N-1:0]  i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [N-1:0]  o_quotient
);
    localparam int unsigned CW = $clog2(N + 1);

    logic [N-1:0]  r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;
    logic          w_ge;

    always_comb begin
        w_sh   = {r_rem, r_q[N-1]};
        w_ge   = (w_sh >= {1'b0, r_dvs});
        w_diff = w_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(N);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[N-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

// ----- sv/llcc_front.sv -----
// Front end: thresholds each pixel, stores it and keeps the column and run sums.
// Depends on llcc_pkg; pushes one record per column toward the back end.
module llcc_front #(
    parameter int unsigned MAX_ROWS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [7:0]                    i_pixel,
    output logic                          o_ready,
    input  logic                          i_room,
    input  logic                          i_mode,
    input  logic [7:0]                    i_thr1,
    input  logic [8:0]                    i_thr2,
    input  logic [$clog2(MAX_ROWS):0]     i_rows,
    output logic                          o_we,
    output logic [$clog2(MAX_ROWS):0]     o_waddr,
    output logic                          o_push,
    output logic [8+$clog2(MAX_ROWS)-1:0] o_w,
    output logic [8+2*$clog2(MAX_ROWS)-1:0] o_m,
    output llcc_pkg::t_col_ctl            o_ctl
);
    import llcc_pkg::*;

    localparam int unsigned RB = $clog2(MAX_ROWS);
    localparam int unsigned WW = 8 + RB;
    localparam int unsigned WM = 8 + 2 * RB;

    logic [RB-1:0] r_row;
    logic          r_bank;
    logic [WW-1:0] r_tw, r_w1, r_w2, n_tw, n_w1, n_w2;
    logic [WM-1:0] r_tm, r_m1, r_m2, n_tm, n_m1, n_m2;
    logic [1:0]    r_prev, n_prev;
    logic [7:0]    w_v1, w_v2;
    logic [WM-1:0] w_mom1, w_mom2;
    logic          w_en2, w_last, w_acc;

    assign w_acc   = i_valid & o_ready;
    assign o_ready = i_room;

    always_comb begin
        w_v1   = (i_pixel > i_thr1) ? i_pixel - i_thr1 : 8'd0;
        w_v2   = (i_pixel > i_thr2[7:0]) ? i_pixel - i_thr2[7:0] : 8'd0;
        w_en2  = ~i_thr2[8];
        w_mom1 = WM'(r_row) * WM'(w_v1);
        w_mom2 = WM'(r_row) * WM'(w_v2);
        n_tw   = r_tw + WW'(w_v1);
        n_tm   = r_tm + w_mom1;
        n_w1   = r_w1;
        n_m1   = r_m1;
        n_w2   = r_w2;
        n_m2   = r_m2;
        n_prev = r_prev;
        // Row 0 never joins a peak-down run.
        if (r_row != '0) begin
            if (w_v1 == 8'd0) begin
                n_prev[0] = 1'b0;
            end else begin
                n_w1      = (r_prev[0] ? r_w1 : '0) + WW'(w_v1);
                n_m1      = (r_prev[0] ? r_m1 : '0) + w_mom1;
                n_prev[0] = 1'b1;
            end
            if (!w_en2) begin
                n_prev[1] = 1'b0;
            end else if (w_v2 == 8'd0) begin
                n_prev[1] = 1'b0;
            end else begin
                n_w2      = (r_prev[1] ? r_w2 : '0) + WW'(w_v2);
                n_m2      = (r_prev[1] ? r_m2 : '0) + w_mom2;
                n_prev[1] = 1'b1;
            end
        end
        w_last = (({1'b0, r_row} + (RB+1)'(1)) >= i_rows);

        o_ctl.bank = r_bank;
        if (!i_mode) begin
            o_w       = n_tw;
            o_m       = n_tm;
            o_ctl.thr = i_thr1;
        end else if (n_w1 != '0) begin
            o_w       = n_w1;
            o_m       = n_m1;
            o_ctl.thr = i_thr1;
        end else if (w_en2) begin
            o_w       = n_w2;
            o_m       = n_m2;
            o_ctl.thr = i_thr2[7:0];
        end else begin
            o_w       = '0;
            o_m       = '0;
            o_ctl.thr = i_thr1;
        end
        o_ctl.found = (o_w != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_bank <= 1'b0;
            r_tw   <= '0;
            r_tm   <= '0;
            r_w1   <= '0;
            r_m1   <= '0;
            r_w2   <= '0;
            r_m2   <= '0;
            r_prev <= 2'b00;
        end else if (w_acc) begin
            if (w_last) begin
                r_row  <= '0;
                r_bank <= ~r_bank;
                r_tw   <= '0;
                r_tm   <= '0;
                r_w1   <= '0;
                r_m1   <= '0;
                r_w2   <= '0;
                r_m2   <= '0;
                r_prev <= 2'b00;
            end else begin
                r_row  <= r_row + RB'(1);
                r_tw   <= n_tw;
                r_tm   <= n_tm;
                r_w1   <= n_w1;
                r_m1   <= n_m1;
                r_w2   <= n_w2;
                r_m2   <= n_m2;
                r_prev <= n_prev;
            end
        end
    end

    assign o_we    = w_acc;
    assign o_waddr = {r_bank, r_row};
    assign o_push  = w_acc & w_last;
endmodule

// ----- sv/llcc_back.sv -----
// Back end: scale, height and centroid-row divisions, then the brightness lookup.
// Depends on llcc_pkg and llcc_div.
module llcc_back #(
    parameter int unsigned MAX_ROWS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  logic [8+$clog2(MAX_ROWS)-1:0]   i_q_w,
    input  logic [8+2*$clog2(MAX_ROWS)-1:0] i_q_m,
    input  logic [$clog2(MAX_ROWS):0]       i_q_rows,
    input  llcc_pkg::t_col_ctl              i_q_ctl,
    output logic                            o_q_pop,
    output logic                            o_re,
    output logic [$clog2(MAX_ROWS):0]       o_raddr,
    input  logic [7:0]                      i_rdata,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [15:0]                     o_height,
    output logic [7:0]                      o_brightness,
    output logic                            o_retire
);
    import llcc_pkg::*;

    localparam int unsigned RB = $clog2(MAX_ROWS);
    localparam int unsigned WW = 8 + RB;
    localparam int unsigned WM = 8 + 2 * RB;
    localparam int unsigned N  = ScaleW + WM;
    localparam int unsigned DW = WW + 1;

    t_back_state   r_state, n_state;
    logic [WW-1:0] r_w;
    logic [WM-1:0] r_m;
    logic [RB:0]   r_rows;
    t_col_ctl      r_ctl;
    logic [ScaleW-1:0] r_scale;
    logic [N-1:0]  r_prod;
    logic [15:0]   r_height;
    logic [RB-1:0] r_idx;
    logic [7:0]    r_bright;
    logic          w_start;
    logic [N-1:0]  w_dvd;
    logic [DW-1:0] w_dvs;
    logic          w_done;
    logic [N-1:0]  w_quo;

    llcc_div #(.N(N), .DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state = r_state;
        w_start = 1'b0;
        w_dvd   = N'(ScaleNum);
        w_dvs   = DW'(r_rows);
        o_q_pop = 1'b0;
        o_re    = 1'b0;
        o_retire = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = B_LOAD;
                end
            end
            B_LOAD: begin
                if (r_ctl.found) begin
                    w_start = 1'b1;
                    n_state = B_SCALE;
                end else begin
                    n_state = B_OUT;
                end
            end
            B_SCALE: begin
                if (w_done) begin
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_state = B_HSTART;
            end
            B_HSTART: begin
                w_start = 1'b1;
                w_dvd   = r_prod;
                w_dvs   = DW'(r_w);
                n_state = B_HGT;
            end
            B_HGT: begin
                // Rounded centroid row: floor((2*m + w) / (2*w)).
                w_dvd = N'({r_m, 1'b0}) + N'(r_w);
                w_dvs = {r_w, 1'b0};
                if (w_done) begin
                    w_start = 1'b1;
                    n_state = B_IDX;
                end
            end
            B_IDX: begin
                if (w_done) begin
                    n_state = B_RD;
                end
            end
            B_RD: begin
                o_re    = 1'b1;
                n_state = B_MEM;
            end
            B_MEM: begin
                n_state = B_OUT;
            end
            B_OUT: begin
                if (i_ready) begin
                    o_retire = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_w      <= i_q_w;
                r_m      <= i_q_m;
                r_rows   <= i_q_rows;
                r_ctl    <= i_q_ctl;
                r_height <= 16'd0;
                r_bright <= 8'd0;
            end
            B_SCALE: begin
                if (w_done) begin
                    r_scale <= w_quo[ScaleW-1:0];
                end
            end
            B_MUL: begin
                r_prod <= N'(r_scale) * N'(r_m);
            end
            B_HGT: begin
                if (w_done) begin
                    r_height <= w_quo[15:0];
                end
            end
            B_IDX: begin
                if (w_done) begin
                    r_idx <= (w_quo >= N'(MAX_ROWS)) ? RB'(MAX_ROWS - 1) : w_quo[RB-1:0];
                end
            end
            B_MEM: begin
                r_bright <= (i_rdata > r_ctl.thr) ? i_rdata - r_ctl.thr : 8'd0;
            end
            default: begin
                r_w <= r_w;
            end
        endcase
    end

    assign o_raddr      = {r_ctl.bank, r_idx};
    assign o_valid      = (r_state == B_OUT);
    assign o_height     = r_height;
    assign o_brightness = r_bright;
endmodule

// ----- sv/laser_line_column_centroid.sv -----
// Top level of the laser line column centroid block.
// Depends on llcc_pkg, llcc_front, llcc_queue, llcc_back and llcc_ram.
//
//  channel   direction  handshake              word
//  pixel     in         i_valid / o_ready      i_pixel
//  result    out        o_valid / i_ready      o_height, o_brightness
//  config    in         i_cfg_we (no wait)     i_cfg_idx, i_cfg_data
//
// Pixels are taken one per cycle while o_ready is high; a column finished by the
// front end is handed through a two-entry queue to the back end, which runs three
// divisions per column in its shared bit-serial divider and skips them when
// nothing was found.
// The pixel store has two banks, so at most two columns are in flight; with
// short columns the divider sets the rate. Reset is synchronous and needs no
// clearing pass.
module laser_line_column_centroid #(
    parameter int unsigned MAX_ROWS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_pixel,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_height,
    output logic [7:0]  o_brightness,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data
);
    import llcc_pkg::*;

    localparam int unsigned RB = $clog2(MAX_ROWS);
    localparam int unsigned WW = 8 + RB;
    localparam int unsigned WM = 8 + 2 * RB;
    localparam int unsigned QW = WW + WM + RB + 1 + ColCtlW;

    localparam logic [1:0] RegMode = 2'd0;
    localparam logic [1:0] RegThr1 = 2'd1;
    localparam logic [1:0] RegThr2 = 2'd2;
    localparam logic [1:0] RegRows = 2'd3;

    logic        r_mode;
    logic [7:0]  r_thr1;
    logic [8:0]  r_thr2;
    logic [10:0] r_rows;
    logic [1:0]  r_pend;
    logic [RB:0] w_rows;

    logic          w_we, w_re, w_push, w_pop, w_retire, w_qv, w_qfull;
    logic [RB:0]   w_waddr, w_raddr;
    logic [7:0]    w_rdata;
    logic [WW-1:0] w_w, w_qw;
    logic [WM-1:0] w_m, w_qm;
    logic [RB:0]   w_qrows;
    t_col_ctl      w_ctl, w_qctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_thr1 <= 8'd0;
            r_thr2 <= 9'h1FF;
            r_rows <= 11'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegMode: r_mode <= i_cfg_data[0];
                RegThr1: r_thr1 <= i_cfg_data[7:0];
                RegThr2: r_thr2 <= i_cfg_data[8:0];
                RegRows: r_rows <= i_cfg_data;
                default: r_mode <= r_mode;
            endcase
        end
    end

    always_comb begin
        if (r_rows == 11'd0) begin
            w_rows = (RB+1)'(1);
        end else if (32'(r_rows) > 32'(MAX_ROWS)) begin
            w_rows = (RB+1)'(MAX_ROWS);
        end else begin
            w_rows = (RB+1)'(r_rows);
        end
    end

    // Columns handed over but not yet delivered; each holds one store bank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            case ({w_push, w_retire})
                2'b10:   r_pend <= r_pend + 2'd1;
                2'b01:   r_pend <= r_pend - 2'd1;
                default: r_pend <= r_pend;
            endcase
        end
    end

    llcc_front #(.MAX_ROWS(MAX_ROWS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_pixel (i_pixel),
        .o_ready (o_ready),
        .i_room  (r_pend != 2'd2),
        .i_mode  (r_mode),
        .i_thr1  (r_thr1),
        .i_thr2  (r_thr2),
        .i_rows  (w_rows),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_push  (w_push),
        .o_w     (w_w),
        .o_m     (w_m),
        .o_ctl   (w_ctl)
    );

    llcc_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_w, w_m, w_rows, w_ctl}),
        .i_pop   (w_pop),
        .o_valid (w_qv),
        .o_full  (w_qfull),
        .o_data  ({w_qw, w_qm, w_qrows, w_qctl})
    );

    // Each bank spans a full power of two so that {bank, row} stays in range.
    llcc_ram #(.WIDTH(8), .DEPTH(2 ** (RB + 1))) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_pixel),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    llcc_back #(.MAX_ROWS(MAX_ROWS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_qv),
        .i_q_w        (w_qw),
        .i_q_m        (w_qm),
        .i_q_rows     (w_qrows),
        .i_q_ctl      (w_qctl),
        .o_q_pop      (w_pop),
        .o_re         (w_re),
        .o_raddr      (w_raddr),
        .i_rdata      (w_rdata),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_height     (o_height),
        .o_brightness (o_brightness),
        .o_retire     (w_retire)
    );

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qfull)
        else $error("column pushed into a full queue");
    a_retire_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_retire |-> r_pend != 2'd0)
        else $error("result delivered with no column pending");
    a_pop_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> r_pend != 2'd0)
        else $error("back end took a column that was never counted");
`endif
endmodule

// ----- tb/laser_line_column_centroid_tb.sv -----
// Self-checking testbench for laser_line_column_centroid.
// Needs only the RTL (llcc_pkg and the top level with its submodules); every result
// word is checked against a built-in column predictor or a directed expected word.
module laser_line_column_centroid_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxRows    = 1024;
    localparam int IdleWait   = 200;
    localparam int CycleLimit = 2000000;

    typedef enum logic [1:0] {
        REG_MODE,
        REG_THR1,
        REG_THR2,
        REG_ROWS
    } t_reg_idx;

    typedef struct {
        bit          is_cfg;
        t_reg_idx    idx;
        logic [10:0] data;
        logic [7:0]  pix;
        bit          typed;
        logic [15:0] h;
        logic [7:0]  b;
    } t_step;

    typedef struct {
        logic [15:0] h;
        logic [7:0]  b;
    } t_centroid;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_pixel = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_height;
    logic [7:0]  o_brightness;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [10:0] i_cfg_data = '0;

    laser_line_column_centroid DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state and its copy of the registers.
    logic [7:0]      col_pixels [MaxRows];
    int unsigned     next_row;
    longint unsigned sum_all, moment_all;
    longint unsigned sum_run1, moment_run1, sum_run2, moment_run2;
    bit [1:0]        in_run;
    bit              cur_mode;
    logic [7:0]      cur_thr1;
    logic [8:0]      cur_thr2;
    logic [10:0]     cur_rows;

    t_centroid   pending_centroids [$];
    t_step       directed [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          send_idle = 0;
    int          recv_stall = 0;

    function automatic int unsigned clip_sub(int unsigned v, int unsigned t);
        return v > t ? v - t : 0;
    endfunction

    function automatic int unsigned rows_in_use();
        if (cur_rows == 0) return 1;
        if (cur_rows > MaxRows) return MaxRows;
        return cur_rows;
    endfunction

    function automatic void clear_column();
        next_row = 0;
        sum_all = 0; moment_all = 0;
        sum_run1 = 0; moment_run1 = 0;
        sum_run2 = 0; moment_run2 = 0;
        in_run = '0;
    endfunction

    // A zero word ends a run; the first nonzero word after that starts a new one.
    task automatic extend_run(input int unsigned v, input int unsigned r, input int b,
                              inout longint unsigned w, inout longint unsigned m);
        if (v == 0) begin
            in_run[b] = 1'b0;
        end else begin
            if (!in_run[b]) begin
                w = 0;
                m = 0;
            end
            w += v;
            m += longint'(r) * v;
            in_run[b] = 1'b1;
        end
    endtask

    function automatic t_centroid locate(longint unsigned w, longint unsigned m,
                                         int unsigned thr, int unsigned rows);
        t_centroid c;
        longint unsigned scale, idx;
        scale = 65536 / rows;
        c.h = 16'((scale * m) / w);
        idx = (2 * m + w) / (2 * w);
        if (idx >= MaxRows) idx = MaxRows - 1;
        c.b = 8'(clip_sub(col_pixels[idx], thr));
        return c;
    endfunction

    task automatic predict_pixel(input logic [7:0] p, output bit done, output t_centroid c);
        int unsigned rows, r, v1;
        rows = rows_in_use();
        r = next_row >= MaxRows ? MaxRows - 1 : next_row;
        col_pixels[r] = p;
        v1 = clip_sub(p, cur_thr1);
        sum_all += v1;
        moment_all += longint'(r) * v1;
        if (r > 0) begin
            extend_run(v1, r, 0, sum_run1, moment_run1);
            if (!cur_thr2[8])
                extend_run(clip_sub(p, cur_thr2[7:0]), r, 1, sum_run2, moment_run2);
            else
                in_run[1] = 1'b0;
        end
        done = (r + 1 >= rows);
        c = '{h: '0, b: '0};
        if (!done) begin
            next_row = r + 1;
        end else begin
            if (!cur_mode) begin
                if (sum_all != 0) c = locate(sum_all, moment_all, cur_thr1, rows);
            end else if (sum_run1 != 0) begin
                c = locate(sum_run1, moment_run1, cur_thr1, rows);
            end else if (!cur_thr2[8] && sum_run2 != 0) begin
                c = locate(sum_run2, moment_run2, cur_thr2[7:0], rows);
            end
            clear_column();
        end
    endtask

    task automatic send_pixel(input logic [7:0] p, input bit typed, input t_centroid fixed);
        bit done;
        t_centroid c;
        if ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            while ($urandom_range(0, 99) < send_idle) @(posedge i_clk);
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= p;
        do @(posedge i_clk); while (!o_ready);
        predict_pixel(p, done, c);
        if (done) pending_centroids.push_back(typed ? fixed : c);
    endtask

    // Registers change only once the block has drained every column.
    task automatic write_reg(input t_reg_idx idx, input logic [10:0] data);
        i_valid <= 1'b0;
        wait (pending_centroids.size() == 0);
        repeat (IdleWait) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MODE: cur_mode = data[0];
            REG_THR1: cur_thr1 = data[7:0];
            REG_THR2: cur_thr2 = data[8:0];
            default:  cur_rows = data;
        endcase
    endtask

    function automatic logic [7:0] pick_pixel();
        int v;
        case ($urandom_range(0, 3))
            0: v = 0;
            1: v = $urandom_range(0, 255);
            2: v = cur_thr1 + $urandom_range(0, 3);
            default: v = 255;
        endcase
        return v > 255 ? 8'd255 : 8'(v);
    endfunction

    function automatic t_step cfg_row(t_reg_idx idx, logic [10:0] data);
        return '{1'b1, idx, data, 8'd0, 1'b0, 16'd0, 8'd0};
    endfunction

    function automatic t_step pix_row(logic [7:0] p, bit typed = 0,
                                      logic [15:0] h = 0, logic [7:0] b = 0);
        return '{1'b0, REG_MODE, 11'd0, p, typed, h, b};
    endfunction

    // Result side: random stalls, checked against the oldest expected word.
    always @(posedge i_clk) begin
        t_centroid want;
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
        if (o_valid && i_ready) begin
            if (pending_centroids.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word h=%0d b=%0d",
                                               o_height, o_brightness);
            end else begin
                want = pending_centroids.pop_front();
                if (o_height !== want.h || o_brightness !== want.b) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected h=%0d b=%0d, got h=%0d b=%0d",
                                 want.h, want.b, o_height, o_brightness);
                end
            end
        end
        if (i_rst_n) i_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    initial begin
        int phase_pixels, col, n;
        t_step s;
        t_centroid fixed;
        cur_mode = 0; cur_thr1 = 0; cur_thr2 = 9'h1FF; cur_rows = 11'd1024;
        clear_column();
        foreach (col_pixels[k]) col_pixels[k] = '0;

        directed.push_back(cfg_row(REG_ROWS, 11'd1));
        directed.push_back(pix_row(8'd255, 1, 16'd0, 8'd255));  // single row, full scale
        directed.push_back(pix_row(8'd0, 1, 16'd0, 8'd0));      // nothing found
        directed.push_back(cfg_row(REG_MODE, 11'd1));
        directed.push_back(pix_row(8'd200, 1, 16'd0, 8'd0));    // row 0 never counts
        directed.push_back(cfg_row(REG_ROWS, 11'd0));           // zero taken as one
        directed.push_back(pix_row(8'd9, 1, 16'd0, 8'd0));
        directed.push_back(cfg_row(REG_ROWS, 11'd4));
        directed.push_back(cfg_row(REG_THR1, 11'd255));
        repeat (3) directed.push_back(pix_row(8'd255));
        directed.push_back(pix_row(8'd255, 1, 16'd0, 8'd0));    // all clipped away
        directed.push_back(cfg_row(REG_THR1, 11'd0));
        directed.push_back(cfg_row(REG_THR2, 11'd10));
        directed.push_back(pix_row(8'd0));
        directed.push_back(pix_row(8'd5));
        directed.push_back(pix_row(8'd0));
        directed.push_back(pix_row(8'd20));                     // latest run wins
        directed.push_back(cfg_row(REG_THR1, 11'd200));
        directed.push_back(cfg_row(REG_THR2, 11'd0));
        directed.push_back(pix_row(8'd0));
        directed.push_back(pix_row(8'd50));
        directed.push_back(pix_row(8'd60));
        directed.push_back(pix_row(8'd0));                      // second threshold rescues
        directed.push_back(cfg_row(REG_MODE, 11'd0));
        directed.push_back(pix_row(8'd0));
        directed.push_back(pix_row(8'd0));
        directed.push_back(pix_row(8'd0));
        directed.push_back(pix_row(8'd255));
        directed.push_back(cfg_row(REG_THR2, 11'h1FF));         // second pass disabled

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            s = directed[k];
            fixed = '{h: s.h, b: s.b};
            if (s.is_cfg) write_reg(s.idx, s.data);
            else send_pixel(s.pix, s.typed, fixed);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 55; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 55; end
                default: begin send_idle = 13; recv_stall = 13; end
            endcase
            phase_pixels = 0;
            col = 0;
            while (phase_pixels < 230) begin
                if (col % 3 == 0) begin
                    write_reg(REG_MODE, 11'($urandom_range(0, 1)));
                    write_reg(REG_THR1, 11'($urandom_range(0, 255)));
                    write_reg(REG_THR2, 11'($urandom_range(0, 511)));
                    if ($urandom_range(0, 9) == 0)
                        write_reg(REG_ROWS, 11'($urandom_range(0, 1)));
                    else
                        write_reg(REG_ROWS, 11'($urandom_range(2, 16)));
                end
                n = rows_in_use();
                repeat (n) send_pixel(pick_pixel(), 0, fixed);
                phase_pixels += n;
                col++;
            end
        end
        i_valid <= 1'b0;

        wait (pending_centroids.size() == 0);
        repeat (IdleWait) @(posedge i_clk);
        if (mismatches == 0 && pending_centroids.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
